// ===== design/rlim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_pkg
// Shared sizes, codes and types of the per-source packet rate limiter.
// ----------------------------------------------------------------------------
package rlim_pkg;

   localparam int Entries    = 16;
   localparam int CountBits  = 16;
   localparam int AddrBits   = 64;
   localparam int LimitBits  = 16;
   localparam int IdxBits    = (Entries > 1) ? $clog2(Entries) : 1;
   localparam int UsedBits   = $clog2(Entries + 1);
   localparam int CsrAddrBits = 2;
   localparam int CsrDataBits = 32;

   localparam logic [CountBits-1:0]   CountMax       = {CountBits{1'b1}};
   localparam logic [LimitBits-1:0]   PassLimitReset = 16'd4;
   localparam logic [CsrAddrBits-1:0] CsrPassLimit   = 2'd0;

   localparam logic ModePacket = 1'b0;
   localparam logic ModeTick   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COMMIT
   } rlim_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic match;
      logic commit;
   } rlim_cmd_type;

endpackage

// ===== design/rlim_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_if
// Valid/ready channels for packet requests and limiter responses.
// ----------------------------------------------------------------------------
interface rlim_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [rlim_pkg::AddrBits-1:0] source_addr_high;
   logic [rlim_pkg::AddrBits-1:0] source_addr_low;

   modport source (output valid, mode, source_addr_high, source_addr_low, input ready);
   modport sink   (input valid, mode, source_addr_high, source_addr_low, output ready);
endinterface

interface rlim_rsp_if;
   logic valid;
   logic ready;
   logic forward;
   logic learned;
   logic table_full;

   modport source (output valid, forward, learned, table_full, input ready);
   modport sink   (input valid, forward, learned, table_full, output ready);
endinterface

// ===== design/per_source_packet_rate_limiter.sv =====
`timescale 1ns / 1ps
// A response becomes valid when the commit step registers it. The sequencer
// steps each request through accept, match and commit, and takes no new one
// until that commit; commit waits while the previous response is still held.
// Reset (synchronous, active high) empties the source table, clears all
// counts and the response slot, and sets the pass limit to 4.
// ----------------------------------------------------------------------------
// per_source_packet_rate_limiter
// Per-source packet rate limiter with address learning and window ticks.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter (
   input  logic                             clock,
   input  logic                             reset,
   rlim_req_if.sink                         req_chan,
   rlim_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rlim_pkg::CsrAddrBits-1:0] csr_paddr,
   input  logic [rlim_pkg::CsrDataBits-1:0] csr_pwdata,
   output logic [rlim_pkg::CsrDataBits-1:0] csr_prdata,
   output logic                             csr_pready
);

   rlim_pkg::rlim_cmd_type         cmd;
   logic [rlim_pkg::LimitBits-1:0] pass_limit;

   rlim_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .pass_limit (pass_limit)
   );

   rlim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   rlim_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .mode             (req_chan.mode),
      .source_addr_high (req_chan.source_addr_high),
      .source_addr_low  (req_chan.source_addr_low),
      .pass_limit       (pass_limit),
      .forward          (rsp_chan.forward),
      .learned          (rsp_chan.learned),
      .table_full       (rsp_chan.table_full)
   );

endmodule

// ===== design/rlim_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_csr
// APB register file holding the pass limit.
// ----------------------------------------------------------------------------
module rlim_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rlim_pkg::CsrAddrBits-1:0] paddr,
   input  logic [rlim_pkg::CsrDataBits-1:0] pwdata,
   output logic [rlim_pkg::CsrDataBits-1:0] prdata,
   output logic                             pready,
   output logic [rlim_pkg::LimitBits-1:0]   pass_limit
);

   logic [rlim_pkg::LimitBits-1:0] pass_limit_ff;
   logic [rlim_pkg::LimitBits-1:0] pass_limit_in;
   logic                           wr_limit;

   assign pready   = 1'b1;
   assign wr_limit = psel && penable && pwrite && (paddr == rlim_pkg::CsrPassLimit);

   always_comb begin
      pass_limit_in = pass_limit_ff;
      if (wr_limit) begin
         pass_limit_in = pwdata[rlim_pkg::LimitBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_limit_ff <= rlim_pkg::PassLimitReset;
      end else begin
         pass_limit_ff <= pass_limit_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr)
         rlim_pkg::CsrPassLimit: begin
            prdata = {{(rlim_pkg::CsrDataBits - rlim_pkg::LimitBits){1'b0}}, pass_limit_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign pass_limit = pass_limit_ff;

endmodule

// ===== design/rlim_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_ctrl
// Sequencer: accept, match, commit; owns the response valid register.
// ----------------------------------------------------------------------------
module rlim_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rlim_pkg::rlim_cmd_type cmd
);

   rlim_pkg::rlim_state_type state_ff;
   rlim_pkg::rlim_state_type state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     out_free;

   // The response slot frees up when empty or when its transaction completes.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlim_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rlim_pkg::ST_MATCH;
            end
         end
         rlim_pkg::ST_MATCH: begin
            state_in = rlim_pkg::ST_COMMIT;
         end
         rlim_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = rlim_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlim_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.match  = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         rlim_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         rlim_pkg::ST_MATCH: begin
            cmd.match = 1'b1;
         end
         rlim_pkg::ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlim_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/rlim_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlim_dpath
// Source table, parallel address match, count update and result register.
// ----------------------------------------------------------------------------
module rlim_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  rlim_pkg::rlim_cmd_type         cmd,
   input  logic                           mode,
   input  logic [rlim_pkg::AddrBits-1:0]  source_addr_high,
   input  logic [rlim_pkg::AddrBits-1:0]  source_addr_low,
   input  logic [rlim_pkg::LimitBits-1:0] pass_limit,
   output logic                           forward,
   output logic                           learned,
   output logic                           table_full
);

   localparam int N  = rlim_pkg::Entries;
   localparam int CB = rlim_pkg::CountBits;
   localparam int IB = rlim_pkg::IdxBits;
   localparam int UB = rlim_pkg::UsedBits;
   localparam int AB = rlim_pkg::AddrBits;

   // Captured transaction
   logic          mode_ff;
   logic [AB-1:0] addr_high_ff;
   logic [AB-1:0] addr_low_ff;

   // Table
   logic [AB-1:0] entry_high_ff [N];
   logic [AB-1:0] entry_low_ff  [N];
   logic [CB-1:0] win_count_ff  [N];
   logic [CB-1:0] win_count_in  [N];
   logic [CB-1:0] last_count_ff [N];
   logic [CB-1:0] last_count_in [N];
   logic [UB-1:0] used_ff;
   logic [UB-1:0] used_in;

   // Match stage
   logic [N-1:0]  match_vec;
   logic          hit_comb;
   logic [IB-1:0] hit_idx_comb;
   logic          hit_ff;
   logic [IB-1:0] hit_idx_ff;

   // Commit stage
   logic          fwd_in;
   logic          lrn_in;
   logic          full_in;
   logic          forward_ff;
   logic          learned_ff;
   logic          table_full_ff;
   logic          room;
   logic          do_learn;
   logic [IB-1:0] new_idx;
   logic [CB-1:0] hit_count;
   logic [CB-1:0] hit_count_inc;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= mode;
         addr_high_ff <= source_addr_high;
         addr_low_ff  <= source_addr_low;
      end
   end

   // Compare against every used entry at once.
   always_comb begin
      for (int k = 0; k < N; k++) begin
         match_vec[k] = (UB'(k) < used_ff) && (entry_high_ff[k] == addr_high_ff) &&
                        (entry_low_ff[k] == addr_low_ff);
      end
   end

   // Lowest matching entry wins.
   always_comb begin
      hit_comb     = |match_vec;
      hit_idx_comb = '0;
      for (int k = N - 1; k >= 0; k--) begin
         if (match_vec[k]) begin
            hit_idx_comb = IB'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         hit_ff     <= hit_comb;
         hit_idx_ff <= hit_idx_comb;
      end
   end

   assign room          = used_ff < UB'(N);
   assign new_idx       = used_ff[IB-1:0];
   assign hit_count     = win_count_ff[hit_idx_ff];
   assign hit_count_inc = (hit_count == rlim_pkg::CountMax) ? hit_count : hit_count + 1'b1;
   assign do_learn      = cmd.commit && (mode_ff == rlim_pkg::ModePacket) && !hit_ff && room;

   always_comb begin
      win_count_in  = win_count_ff;
      last_count_in = last_count_ff;
      used_in       = used_ff;
      fwd_in        = 1'b0;
      lrn_in        = 1'b0;
      full_in       = 1'b0;
      if (cmd.commit) begin
         if (mode_ff == rlim_pkg::ModeTick) begin
            // Unused entries hold zero counts, so shifting all of them is harmless.
            for (int k = 0; k < N; k++) begin
               last_count_in[k] = win_count_ff[k];
               win_count_in[k]  = '0;
            end
         end else if (hit_ff) begin
            win_count_in[hit_idx_ff] = hit_count_inc;
            fwd_in = last_count_ff[hit_idx_ff] < pass_limit;
         end else if (room) begin
            win_count_in[new_idx]  = CB'(1);
            last_count_in[new_idx] = '0;
            used_in                = used_ff + 1'b1;
            lrn_in                 = 1'b1;
         end else begin
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int k = 0; k < N; k++) begin
            win_count_ff[k]  <= '0;
            last_count_ff[k] <= '0;
         end
      end else begin
         used_ff       <= used_in;
         win_count_ff  <= win_count_in;
         last_count_ff <= last_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_learn) begin
         entry_high_ff[new_idx] <= addr_high_ff;
         entry_low_ff[new_idx]  <= addr_low_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         forward_ff    <= fwd_in;
         learned_ff    <= lrn_in;
         table_full_ff <= full_in;
      end
   end

   assign forward    = forward_ff;
   assign learned    = learned_ff;
   assign table_full = table_full_ff;

endmodule
